>>> src/sews_pkg.sv
// Shared types and constants for the scan encoder window sequencer.
// No dependencies; imported by sews_step and scan_encoder_window_sequencer.
package sews_pkg;

    localparam int unsigned TIME_W   = 16;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned DRIVE_W  = 2;
    localparam int unsigned TP_W     = 10;
    localparam int unsigned ZP_W     = 12;
    localparam int unsigned HW_W     = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 48;

    localparam logic [PERIOD_W-1:0] PERIOD_CLAMP     = 10'd1000;
    localparam logic [15:0]         REF_SAMPLE_LIMIT = 16'd2000;
    localparam logic signed [17:0]  REF_MAX          = 18'sd20000;
    localparam logic signed [15:0]  REF_FALLBACK     = 16'sd200;
    localparam logic [10:0]         DRIVE_DEADBAND   = 11'd5;

    localparam logic [TP_W-1:0] TARGET_PERIOD_RST = 10'd257;
    localparam logic [ZP_W-1:0] ZERO_POSITION_RST = 12'd750;
    localparam logic [HW_W-1:0] HALF_WIDTH_RST    = 11'd145;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POSITION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH    = 2'd2;

    localparam logic [DRIVE_W-1:0] DRIVE_HOLD = 2'd0;
    localparam logic [DRIVE_W-1:0] DRIVE_SLOW = 2'd1;
    localparam logic [DRIVE_W-1:0] DRIVE_FAST = 2'd2;

    localparam logic [WORD_W-1:0] SYNC_CODE_DIFFER = 16'd3;

    typedef struct packed {
        logic [TP_W-1:0] target_period;
        logic [ZP_W-1:0] zero_position;
        logic [HW_W-1:0] half_width;
    } sews_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] edge_time;
        logic              sync_level;
        logic [15:0]       distance_sample;
    } sews_in_t;

    typedef struct packed {
        logic                send_valid;
        logic [WORD_W-1:0]   send_word;
        logic                header_due;
        logic [DRIVE_W-1:0]  motor_drive;
        logic [POS_W-1:0]    rotation_length;
        logic [PERIOD_W-1:0] edge_period;
    } sews_out_t;

endpackage

>>> src/scan_encoder_window_sequencer.sv
// Top level of the scan encoder window sequencer: stream ports, configuration
// registers and result register. Depends on sews_pkg and sews_step.

// Each input beat is one encoder edge and produces exactly one result beat.
// The block takes one edge per clock cycle unless a held result stalls it; the
// result is registered and appears in the cycle after acceptance, and the
// tracking state is updated in that same cycle, so back-to-back edges see each
// other's effect. A single result register holds a waiting beat, and a new
// edge is taken whenever that register is empty or being drained. Configuration
// writes are always ready and should be issued only while no result is pending.
module scan_encoder_window_sequencer
    import sews_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: edge_time[15:0], sync_level[16], distance_sample[32:17].
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: send_valid[0], send_word[16:1], header_due[17],
    // motor_drive[19:18], rotation_length[35:20], edge_period[45:36].
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sews_cfg_t cfg_reg;
    sews_in_t  in_beat;
    sews_out_t step_result;
    sews_out_t out_reg;
    logic      out_valid_reg;
    logic      accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    assign in_beat.edge_time       = s_tdata[15:0];
    assign in_beat.sync_level      = s_tdata[16];
    assign in_beat.distance_sample = s_tdata[32:17];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_period <= TARGET_PERIOD_RST;
            cfg_reg.zero_position <= ZERO_POSITION_RST;
            cfg_reg.half_width    <= HALF_WIDTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TARGET_PERIOD: cfg_reg.target_period <= cfg_data[TP_W-1:0];
                CFG_ZERO_POSITION: cfg_reg.zero_position <= cfg_data[ZP_W-1:0];
                CFG_HALF_WIDTH:    cfg_reg.half_width    <= cfg_data[HW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sews_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_beat (in_beat),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.edge_period, out_reg.rotation_length,
                       out_reg.motor_drive, out_reg.header_due, out_reg.send_word,
                       out_reg.send_valid};

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("Input stalled while the result register is empty.");

    a_result_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("Accepted edge produced no result beat.");

    a_drive_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:18] != 2'b11)
        else $error("Motor drive carries an unused code.");

    a_period_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[45:36] <= PERIOD_CLAMP)
        else $error("Edge period exceeds the clamp.");

    a_header_no_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[17] && m_tdata[0]))
        else $error("Header pulse coincides with a send word.");
`endif

endmodule

>>> src/sews_step.sv
// Per-edge state update and result logic of the window sequencer.
// Holds the tracking state; depends on sews_pkg.
module sews_step
    import sews_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  sews_in_t  in_beat,
    input  sews_cfg_t cfg,
    output sews_out_t result
);

    logic [TIME_W-1:0]   last_time_reg;
    logic [PERIOD_W-1:0] period_now_reg;
    logic [POS_W-1:0]    position_reg;
    logic [POS_W-1:0]    revolution_count_reg;
    logic                capturing_reg;
    logic                sync_at_start_reg;
    logic                sync_at_stop_reg;
    logic signed [15:0]  zero_reference_reg;

    logic [TIME_W-1:0]   last_time_next;
    logic [PERIOD_W-1:0] period_now_next;
    logic [POS_W-1:0]    position_next;
    logic [POS_W-1:0]    revolution_count_next;
    logic                capturing_next;
    logic                sync_at_start_next;
    logic                sync_at_stop_next;
    logic signed [15:0]  zero_reference_next;

    logic [TIME_W-1:0]   delta;
    logic [PERIOD_W-1:0] period;
    logic [POS_W-1:0]    pos_inc;
    logic                zero_index;
    logic [POS_W-1:0]    win_open_pos;
    logic [POS_W-1:0]    win_close_pos;
    logic [POS_W-1:0]    header_pos;
    logic [POS_W-1:0]    sync_pos;
    logic signed [17:0]  ref_ext;
    logic signed [17:0]  ref_diff;
    logic signed [17:0]  ref_step_q;
    logic signed [17:0]  ref_sum;
    logic [WORD_W-1:0]   sync_word;
    logic [10:0]         period_ext;
    logic [10:0]         target_ext;

    always_comb begin
        delta      = in_beat.edge_time - last_time_reg;
        period     = (delta > {6'd0, PERIOD_CLAMP}) ? PERIOD_CLAMP : delta[PERIOD_W-1:0];
        pos_inc    = position_reg + 16'd1;
        zero_index = {period_now_reg, 1'b0} < {1'b0, period};

        win_open_pos  = {4'd0, cfg.zero_position} + {5'd0, cfg.half_width};
        win_close_pos = {4'd0, cfg.zero_position} - {5'd0, cfg.half_width};
        header_pos    = {4'd0, cfg.zero_position} - 16'd1;
        sync_pos      = win_close_pos + 16'd1;

        ref_ext    = {{2{zero_reference_reg[15]}}, zero_reference_reg};
        ref_diff   = $signed({2'b00, in_beat.distance_sample}) - ref_ext;
        ref_step_q = ref_diff[17] ? ((ref_diff + 18'sd7) >>> 3) : (ref_diff >>> 3);
        ref_sum    = ref_ext + ref_step_q;

        sync_word  = (sync_at_start_reg != sync_at_stop_reg) ? SYNC_CODE_DIFFER
                   : {15'd0, sync_at_start_reg} + 16'd1;

        last_time_next        = in_beat.edge_time;
        period_now_next       = period;
        position_next         = zero_index ? '0 : pos_inc;
        revolution_count_next = zero_index ? pos_inc : revolution_count_reg;
        capturing_next        = capturing_reg;
        sync_at_start_next    = sync_at_start_reg;
        sync_at_stop_next     = sync_at_stop_reg;
        zero_reference_next   = zero_reference_reg;

        result = '0;

        if (!capturing_reg && position_next == win_open_pos) begin
            capturing_next     = 1'b1;
            sync_at_start_next = in_beat.sync_level;
        end else if (capturing_reg && position_next == win_close_pos) begin
            capturing_next    = 1'b0;
            sync_at_stop_next = in_beat.sync_level;
        end else if (!capturing_reg && position_next == header_pos) begin
            result.header_due = 1'b1;
            if (in_beat.distance_sample < REF_SAMPLE_LIMIT) begin
                if (ref_sum > REF_MAX || ref_sum < 18'sd0) begin
                    zero_reference_next = REF_FALLBACK;
                end else begin
                    zero_reference_next = ref_sum[15:0];
                end
            end
        end else if (!capturing_reg && position_next == sync_pos) begin
            result.send_valid = 1'b1;
            result.send_word  = sync_word;
        end

        if (capturing_next) begin
            result.send_valid = 1'b1;
            result.send_word  = ($signed({2'b00, in_beat.distance_sample}) > ref_ext)
                              ? (in_beat.distance_sample - zero_reference_reg) : '0;
        end

        period_ext = {1'b0, period};
        target_ext = {1'b0, cfg.target_period};
        if (target_ext > period_ext + DRIVE_DEADBAND) begin
            result.motor_drive = DRIVE_SLOW;
        end else if (period_ext > target_ext + DRIVE_DEADBAND) begin
            result.motor_drive = DRIVE_FAST;
        end else begin
            result.motor_drive = DRIVE_HOLD;
        end

        result.rotation_length = revolution_count_next;
        result.edge_period     = period;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg        <= '0;
            period_now_reg       <= '0;
            position_reg         <= '0;
            revolution_count_reg <= '0;
            capturing_reg        <= 1'b0;
            sync_at_start_reg    <= 1'b0;
            sync_at_stop_reg     <= 1'b0;
            zero_reference_reg   <= '0;
        end else if (accept) begin
            last_time_reg        <= last_time_next;
            period_now_reg       <= period_now_next;
            position_reg         <= position_next;
            revolution_count_reg <= revolution_count_next;
            capturing_reg        <= capturing_next;
            sync_at_start_reg    <= sync_at_start_next;
            sync_at_stop_reg     <= sync_at_stop_next;
            zero_reference_reg   <= zero_reference_next;
        end
    end

endmodule

>>> tb/sv/tb_scan_encoder_window_sequencer.sv
// Self-checking testbench for scan_encoder_window_sequencer: a directed edge table,
// then randomized encoder rotations under several register settings and idle patterns.
// Depends on sews_pkg and the RTL; beats are checked against typed rows or a local predictor.
module tb_scan_encoder_window_sequencer
    import sews_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DIRECTED_COUNT = 20;

    typedef struct packed {
        logic [15:0] edge_time;
        logic        sync_level;
        logic [15:0] distance_sample;
        logic        typed;
        sews_out_t   result;
    } directed_row_t;

    // Fields per row: edge_time, sync_level, distance_sample, typed flag, then
    // send_valid, send_word, header_due, motor_drive, rotation_length, edge_period.
    localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        {16'd0,     1'b0, 16'd0,     1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd0, 10'd0},
        {16'd65535, 1'b1, 16'd65535, 1'b1, 1'b0, 16'd0, 1'b0, DRIVE_FAST, 16'd2, 10'd1000},
        {16'd999,   1'b0, 16'd1999,  1'b1, 1'b0, 16'd0, 1'b0, DRIVE_FAST, 16'd2, 10'd1000},
        {16'd2000,  1'b1, 16'd2000,  1'b1, 1'b0, 16'd0, 1'b0, DRIVE_FAST, 16'd2, 10'd1000},
        {16'd2257,  1'b0, 16'd0,     1'b1, 1'b0, 16'd0, 1'b0, DRIVE_HOLD, 16'd2, 10'd257},
        {16'd2519,  1'b1, 16'd1,     1'b1, 1'b0, 16'd0, 1'b0, DRIVE_HOLD, 16'd2, 10'd262},
        {16'd2771,  1'b0, 16'd32768, 1'b1, 1'b0, 16'd0, 1'b0, DRIVE_HOLD, 16'd2, 10'd252},
        {16'd3034,  1'b1, 16'd21845, 1'b1, 1'b0, 16'd0, 1'b0, DRIVE_FAST, 16'd2, 10'd263},
        {16'd3285,  1'b0, 16'd43690, 1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd2, 10'd251},
        {16'd3285,  1'b1, 16'd100,   1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd2, 10'd0},
        {16'd3286,  1'b0, 16'd65535, 1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd9, 10'd1},
        {16'd3288,  1'b1, 16'd2000,  1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd9, 10'd2},
        {16'd3293,  1'b0, 16'd1999,  1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd2, 10'd5},
        {16'd3303,  1'b1, 16'd7,     1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd2, 10'd10},
        {16'd3323,  1'b0, 16'd4000,  1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd2, 10'd20},
        {16'd3364,  1'b1, 16'd12345, 1'b1, 1'b0, 16'd0, 1'b0, DRIVE_SLOW, 16'd3, 10'd41},
        {16'd4364,  1'b0, 16'd500,   1'b1, 1'b0, 16'd0, 1'b0, DRIVE_FAST, 16'd1, 10'd1000},
        {16'd4364,  1'b1, 16'd65534, 1'b0, 1'b0, 16'd0, 1'b0, DRIVE_HOLD, 16'd0, 10'd0},
        {16'd4363,  1'b0, 16'd1,     1'b0, 1'b0, 16'd0, 1'b0, DRIVE_HOLD, 16'd0, 10'd0},
        {16'd4863,  1'b1, 16'd30000, 1'b0, 1'b0, 16'd0, 1'b0, DRIVE_HOLD, 16'd0, 10'd0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [TP_W-1:0]     set_target_period = TARGET_PERIOD_RST;
    logic [ZP_W-1:0]     set_zero_position = ZERO_POSITION_RST;
    logic [HW_W-1:0]     set_half_width = HALF_WIDTH_RST;
    logic [TIME_W-1:0]   last_stamp = '0;
    logic [PERIOD_W-1:0] cur_period = '0;
    logic [POS_W-1:0]    enc_position = '0;
    logic [POS_W-1:0]    rotation_count = '0;
    logic                capturing = 1'b0;
    logic                sync_start = 1'b0;
    logic                sync_stop = 1'b0;
    int                  zero_ref = 0;

    sews_out_t pending_results [$];
    sews_out_t observed;
    sews_out_t predicted;
    logic [TIME_W-1:0] edge_clock = '0;
    int last_gap = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 78;
    int mismatches = 0;
    int results_checked = 0;
    int edges_sent = 0;
    int words_seen = 0;
    int headers_seen = 0;
    int cycle_count = 0;

    scan_encoder_window_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic sews_out_t predict_edge(input logic [TIME_W-1:0] stamp,
                                               input logic sync,
                                               input logic [15:0] sample);
        sews_out_t res;
        logic [POS_W-1:0] win_open_pos;
        logic [POS_W-1:0] win_close_pos;
        logic [POS_W-1:0] header_pos;
        logic [POS_W-1:0] sync_pos;
        logic [TIME_W-1:0] elapsed;
        logic [PERIOD_W-1:0] period;
        int prev_period;
        int zref;
        int err;
        win_open_pos = 16'(set_zero_position) + 16'(set_half_width);
        win_close_pos = 16'(set_zero_position) - 16'(set_half_width);
        header_pos = 16'(set_zero_position) - 16'd1;
        sync_pos = win_close_pos + 16'd1;
        elapsed = stamp - last_stamp;
        period = (elapsed > PERIOD_CLAMP) ? PERIOD_CLAMP : elapsed[PERIOD_W-1:0];
        prev_period = int'(cur_period);
        last_stamp = stamp;
        cur_period = period;
        res = '0;
        enc_position = enc_position + 16'd1;
        if (prev_period * 2 < int'(period)) begin
            rotation_count = enc_position;
            enc_position = '0;
        end
        if (!capturing && enc_position == win_open_pos) begin
            capturing = 1'b1;
            sync_start = sync;
        end else if (capturing && enc_position == win_close_pos) begin
            capturing = 1'b0;
            sync_stop = sync;
        end else if (!capturing && enc_position == header_pos) begin
            if (sample < REF_SAMPLE_LIMIT) begin
                zref = zero_ref + (int'(sample) - zero_ref) / 8;
                if (zref > int'(REF_MAX) || zref < 0) begin
                    zref = int'(REF_FALLBACK);
                end
                zero_ref = zref;
            end
            res.header_due = 1'b1;
        end else if (!capturing && enc_position == sync_pos) begin
            res.send_valid = 1'b1;
            res.send_word = (sync_start != sync_stop) ? SYNC_CODE_DIFFER
                                                      : {15'd0, sync_start} + 16'd1;
        end
        if (capturing) begin
            res.send_valid = 1'b1;
            res.send_word = (int'(sample) > zero_ref) ? 16'(int'(sample) - zero_ref) : '0;
        end
        err = int'(set_target_period) - int'(period);
        if (err > int'(DRIVE_DEADBAND)) begin
            res.motor_drive = DRIVE_SLOW;
        end else if (err < -int'(DRIVE_DEADBAND)) begin
            res.motor_drive = DRIVE_FAST;
        end else begin
            res.motor_drive = DRIVE_HOLD;
        end
        res.rotation_length = rotation_count;
        res.edge_period = period;
        return res;
    endfunction

    task automatic send_edge(input logic [TIME_W-1:0] stamp, input logic sync,
                             input logic [15:0] sample, input logic typed,
                             input sews_out_t typed_result);
        int gap;
        sews_out_t res;
        logic [TIME_W-1:0] elapsed;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {7'd0, sample, sync, stamp};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        res = predict_edge(stamp, sync, sample);
        pending_results.push_back(typed ? typed_result : res);
        elapsed = stamp - edge_clock;
        last_gap = (elapsed > 16'd1000) ? 1000 : int'(elapsed);
        edge_clock = stamp;
        edges_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_config(input logic [CFG_DATA_W-1:0] target,
                                input logic [CFG_DATA_W-1:0] zero_at,
                                input logic [CFG_DATA_W-1:0] half);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [CFG_DATA_W-1:0] vals [3];
        idx = '{CFG_TARGET_PERIOD, CFG_ZERO_POSITION, CFG_HALF_WIDTH};
        vals = '{target, zero_at, half};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                CFG_TARGET_PERIOD: set_target_period = vals[i][TP_W-1:0];
                CFG_ZERO_POSITION: set_zero_position = vals[i][ZP_W-1:0];
                CFG_HALF_WIDTH:    set_half_width = vals[i][HW_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // One rotation: a run of mostly steady edges followed by the long edge meant to mark the index.
    task automatic emit_rotation(input int length, input int base, input int noise_pct);
        int spread;
        int gap;
        logic hold_sync;
        logic sync;
        logic sync_per_beat;
        logic [TIME_W-1:0] stamp;
        logic [15:0] sample;
        spread = base / 4;
        hold_sync = 1'($urandom_range(1));
        sync_per_beat = ($urandom_range(99) < 30);
        for (int k = 0; k <= length; k++) begin
            if (k == length) begin
                if (2 * last_gap + 1 > 1000 || $urandom_range(3) == 0) begin
                    gap = int'($urandom_range(65535, 1001));
                end else begin
                    gap = int'($urandom_range(1000, 2 * last_gap + 1));
                end
                stamp = edge_clock + 16'(gap);
            end else if (int'($urandom_range(99)) < noise_pct) begin
                stamp = 16'($urandom);
            end else begin
                gap = base + int'($urandom_range(2 * spread)) - spread;
                stamp = edge_clock + 16'(gap);
            end
            sync = sync_per_beat ? 1'($urandom_range(1)) : hold_sync;
            case ($urandom_range(3))
                0: sample = 16'($urandom_range(2100));
                1: sample = 16'($urandom);
                2: sample = 16'($urandom_range(80)) + 16'(zero_ref);
                default: sample = $urandom_range(1) ? 16'd1999 : 16'd2000;
            endcase
            send_edge(stamp, sync, sample, 1'b0, '0);
        end
    endtask

    task automatic run_rotations(input int quota);
        int sent;
        int open_at;
        int lo;
        int hi;
        int length;
        open_at = int'(set_zero_position) + int'(set_half_width);
        if (open_at < 70) begin
            lo = (open_at > 4) ? open_at - 4 : 1;
            hi = open_at + 8;
        end else begin
            lo = 40;
            hi = 70;
        end
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99) < 80) begin
                length = int'($urandom_range(hi, lo));
            end else begin
                length = int'($urandom_range(hi, 1));
            end
            emit_rotation(length, int'($urandom_range(300, 1)), 10);
            sent += length + 1;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            observed.send_valid = m_tdata[0];
            observed.send_word = m_tdata[16:1];
            observed.header_due = m_tdata[17];
            observed.motor_drive = m_tdata[19:18];
            observed.rotation_length = m_tdata[35:20];
            observed.edge_period = m_tdata[45:36];
            if (pending_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("Result beat with none expected: tdata=%h", m_tdata);
                end
                mismatches++;
            end else begin
                predicted = pending_results.pop_front();
                if (observed.send_valid !== predicted.send_valid
                        || observed.send_word !== predicted.send_word
                        || observed.header_due !== predicted.header_due
                        || observed.motor_drive !== predicted.motor_drive
                        || observed.rotation_length !== predicted.rotation_length
                        || observed.edge_period !== predicted.edge_period) begin
                    if (mismatches < 10) begin
                        $display("Mismatch at result %0d: expected valid=%0d word=%0d hdr=%0d %s",
                                 results_checked, predicted.send_valid, predicted.send_word,
                                 predicted.header_due, "");
                        $display("    expected drive=%0d rotation=%0d period=%0d",
                                 predicted.motor_drive, predicted.rotation_length,
                                 predicted.edge_period);
                        $display("    got valid=%0d word=%0d hdr=%0d drive=%0d rotation=%0d period=%0d",
                                 observed.send_valid, observed.send_word, observed.header_due,
                                 observed.motor_drive, observed.rotation_length,
                                 observed.edge_period);
                    end
                    mismatches++;
                end
                results_checked++;
                if (observed.send_valid) begin
                    words_seen++;
                end
                if (observed.header_due) begin
                    headers_seen++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_edge(DIRECTED_ROWS[i].edge_time, DIRECTED_ROWS[i].sync_level,
                      DIRECTED_ROWS[i].distance_sample, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].result);
        end

        // Reset window settings need one full long rotation to reach header and capture.
        emit_rotation(1, 257, 0);
        emit_rotation(900, 257, 0);

        send_idle_pct = 78;
        recv_idle_pct = 24;
        drain_results();
        write_config(12'hFFF, 12'd20, 12'd6);
        run_rotations(150);
        drain_results();
        write_config(12'd0, 12'd12, 12'd11);
        run_rotations(120);
        drain_results();
        write_config(12'd600, 12'd3, 12'd0);
        run_rotations(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain_results();
        write_config(12'd1000, 12'd4095, 12'hFFF);
        run_rotations(30);
        drain_results();
        write_config(12'd100, 12'd0, 12'd2);
        run_rotations(60);
        drain_results();
        write_config(12'd257, 12'd30, 12'd1);
        run_rotations(80);
        drain_results();
        run_rotations(80);

        drain_results();
        repeat (2) @(posedge aclk);
        $display("Checked %0d result beats from %0d encoder edges over seven register settings.",
                 results_checked, edges_sent);
        $display("They held %0d sent words and %0d header pulses; %0d beats mismatched.",
                 words_seen, headers_seen, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
